@@ rtl/sha_pkg.sv @@
`default_nettype none
package sha_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROUND,
        ST_FOLD,
        ST_PAD,
        ST_OUT
    } sha_state_t;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    localparam logic [255:0] INIT_H = {
        32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
        32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
    };

    function automatic logic [31:0] round_k(input logic [5:0] idx);
        logic [31:0] k;
        unique case (idx)
            6'd0: k = 32'h428A2F98;  6'd1: k = 32'h71374491;
            6'd2: k = 32'hB5C0FBCF;  6'd3: k = 32'hE9B5DBA5;
            6'd4: k = 32'h3956C25B;  6'd5: k = 32'h59F111F1;
            6'd6: k = 32'h923F82A4;  6'd7: k = 32'hAB1C5ED5;
            6'd8: k = 32'hD807AA98;  6'd9: k = 32'h12835B01;
            6'd10: k = 32'h243185BE; 6'd11: k = 32'h550C7DC3;
            6'd12: k = 32'h72BE5D74; 6'd13: k = 32'h80DEB1FE;
            6'd14: k = 32'h9BDC06A7; 6'd15: k = 32'hC19BF174;
            6'd16: k = 32'hE49B69C1; 6'd17: k = 32'hEFBE4786;
            6'd18: k = 32'h0FC19DC6; 6'd19: k = 32'h240CA1CC;
            6'd20: k = 32'h2DE92C6F; 6'd21: k = 32'h4A7484AA;
            6'd22: k = 32'h5CB0A9DC; 6'd23: k = 32'h76F988DA;
            6'd24: k = 32'h983E5152; 6'd25: k = 32'hA831C66D;
            6'd26: k = 32'hB00327C8; 6'd27: k = 32'hBF597FC7;
            6'd28: k = 32'hC6E00BF3; 6'd29: k = 32'hD5A79147;
            6'd30: k = 32'h06CA6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27B70A85; 6'd33: k = 32'h2E1B2138;
            6'd34: k = 32'h4D2C6DFC; 6'd35: k = 32'h53380D13;
            6'd36: k = 32'h650A7354; 6'd37: k = 32'h766A0ABB;
            6'd38: k = 32'h81C2C92E; 6'd39: k = 32'h92722C85;
            6'd40: k = 32'hA2BFE8A1; 6'd41: k = 32'hA81A664B;
            6'd42: k = 32'hC24B8B70; 6'd43: k = 32'hC76C51A3;
            6'd44: k = 32'hD192E819; 6'd45: k = 32'hD6990624;
            6'd46: k = 32'hF40E3585; 6'd47: k = 32'h106AA070;
            6'd48: k = 32'h19A4C116; 6'd49: k = 32'h1E376C08;
            6'd50: k = 32'h2748774C; 6'd51: k = 32'h34B0BCB5;
            6'd52: k = 32'h391C0CB3; 6'd53: k = 32'h4ED8AA4A;
            6'd54: k = 32'h5B9CCA4F; 6'd55: k = 32'h682E6FF3;
            6'd56: k = 32'h748F82EE; 6'd57: k = 32'h78A5636F;
            6'd58: k = 32'h84C87814; 6'd59: k = 32'h8CC70208;
            6'd60: k = 32'h90BEFFFA; 6'd61: k = 32'hA4506CEB;
            6'd62: k = 32'hBEF9A3F7; 6'd63: k = 32'hC67178F2;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

endpackage
`default_nettype wire

@@ rtl/sha256_hasher_unit.sv @@
`default_nettype none
// channel   signals                                       direction
// in        in_valid, in_stall, message_byte, has_byte,   into block
//           ends_message
// out       out_valid, out_stall, digest_word,            out of block
//           word_number, final_word
// a plain byte leaves the sequencer idle, ready for the next byte; a byte that
// fills a block holds the input through the load (16 word reads, each read
// registered), 64 rounds of the one round unit and a fold. an end transaction adds
// padding (one write per remaining byte) and one or two compressions, then
// eight digest words. in_stall is high whenever the sequencer is not idle.
// reset sets the initial hash values and a zero byte count at once.
// out_stall holds the current digest word in place.
module sha256_hasher_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  message_byte,
    input  wire logic        has_byte,
    input  wire logic        ends_message,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [31:0]      digest_word,
    output logic [2:0]       word_number,
    output logic             final_word
);
    import sha_pkg::*;

    sha_state_t state_reg, state_next;

    logic [31:0]  block_mem [16];
    logic [31:0]  rd_word_reg;
    logic [31:0]  w_reg [16];
    logic [31:0]  h_reg [8];
    logic [31:0]  a_reg, b_reg, c_reg, d_reg, e_reg, f_reg, g_reg, hh_reg;
    logic [60:0]  bytes_reg;
    logic [6:0]   cnt_reg;
    logic         ending_reg;
    logic         second_reg;
    logic         fresh_reg;
    logic [5:0]   pad_reg;
    logic [2:0]   word_reg;

    logic         mem_we;
    logic [5:0]   mem_waddr;
    logic [7:0]   mem_wdata;
    logic [3:0]   rd_idx;
    logic         accept;
    logic         out_take;

    assign accept   = in_valid && !in_stall;
    assign out_take = out_valid && !out_stall;
    assign in_stall = (state_reg != ST_IDLE);

    // byte memory kept as 16 words: one byte-lane write, one word read per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            block_mem[mem_waddr[5:2]][{~mem_waddr[1:0], 3'b000} +: 8] <= mem_wdata;
        end
        rd_word_reg <= block_mem[rd_idx];
    end

    // load: cnt 0..16, read issued for word cnt, data lands in rd_word_reg in the next cycle
    assign rd_idx = cnt_reg[3:0];

    logic [5:0]   fill;
    logic [63:0]  bit_len;
    assign fill    = bytes_reg[5:0];
    assign bit_len = {bytes_reg, 3'b000};

    // pad byte for position pad_reg
    logic [7:0] pad_byte;
    always_comb
    begin
        if (pad_reg == fill && !second_reg)
        begin
            pad_byte = PAD_BYTE;
        end
        else if (pad_reg >= 6'd56 && !(fill >= 6'd56 && !second_reg))
        begin
            pad_byte = bit_len[8*(6'd63 - pad_reg) +: 8];
        end
        else
        begin
            pad_byte = 8'h00;
        end
    end

    // round unit
    logic [5:0]  rnd;
    logic [31:0] w_cur, w_new, s0w, s1w, s1, s0, ch, maj, t1, t2;
    assign rnd = cnt_reg[5:0];
    assign s0w = {w_reg[1][6:0], w_reg[1][31:7]} ^ {w_reg[1][17:0], w_reg[1][31:18]}
                 ^ (w_reg[1] >> 3);
    assign s1w = {w_reg[14][16:0], w_reg[14][31:17]} ^ {w_reg[14][18:0], w_reg[14][31:19]}
                 ^ (w_reg[14] >> 10);
    assign w_new = w_reg[0] + s0w + w_reg[9] + s1w;
    assign w_cur = w_reg[0];
    assign s1 = {e_reg[5:0], e_reg[31:6]} ^ {e_reg[10:0], e_reg[31:11]}
                ^ {e_reg[24:0], e_reg[31:25]};
    assign ch = (e_reg & f_reg) ^ (~e_reg & g_reg);
    assign t1 = hh_reg + s1 + ch + round_k(rnd) + w_cur;
    assign s0 = {a_reg[1:0], a_reg[31:2]} ^ {a_reg[12:0], a_reg[31:13]}
                ^ {a_reg[21:0], a_reg[31:22]};
    assign maj = (a_reg & b_reg) ^ (a_reg & c_reg) ^ (b_reg & c_reg);
    assign t2 = s0 + maj;

    always_comb
    begin
        state_next = state_reg;
        mem_we     = 1'b0;
        mem_waddr  = pad_reg;
        mem_wdata  = pad_byte;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && has_byte)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = fill;
                    mem_wdata = message_byte;
                    if (fill == 6'd63)
                    begin
                        state_next = ST_LOAD;
                    end
                    else if (ends_message)
                    begin
                        state_next = ST_PAD;
                    end
                end
                else if (accept && ends_message)
                begin
                    state_next = ST_PAD;
                end
            end
            ST_LOAD:
            begin
                if (cnt_reg == 7'd16)
                begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND:
            begin
                if (cnt_reg == 7'd63)
                begin
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD:
            begin
                if (!ending_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (fresh_reg || (fill >= 6'd56 && !second_reg))
                begin
                    state_next = ST_PAD;
                end
                else
                begin
                    state_next = ST_OUT;
                end
            end
            ST_PAD:
            begin
                mem_we = 1'b1;
                if (pad_reg == 6'd63)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_OUT:
            begin
                if (out_take && word_reg == 3'd7)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_reg  <= '0;
            cnt_reg    <= '0;
            ending_reg <= 1'b0;
            second_reg <= 1'b0;
            fresh_reg  <= 1'b0;
            pad_reg    <= '0;
            word_reg   <= '0;
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= INIT_H[32*(7-i) +: 32];
            end
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    cnt_reg    <= '0;
                    second_reg <= 1'b0;
                    word_reg   <= '0;
                    if (accept)
                    begin
                        ending_reg <= ends_message;
                        // a full block plus end mark pads a fresh block
                        fresh_reg  <= has_byte && fill == 6'd63 && ends_message;
                        if (has_byte)
                        begin
                            bytes_reg <= bytes_reg + 61'd1;
                            pad_reg   <= fill + 6'd1;
                        end
                        else
                        begin
                            pad_reg <= fill;
                        end
                    end
                end
                ST_LOAD:
                begin
                    cnt_reg <= (cnt_reg == 7'd16) ? 7'd0 : cnt_reg + 7'd1;
                end
                ST_ROUND:
                begin
                    cnt_reg <= cnt_reg + 7'd1;
                end
                ST_FOLD:
                begin
                    cnt_reg <= '0;
                    for (int i = 0; i < 8; i++)
                    begin
                        h_reg[i] <= h_reg[i] + (i == 0 ? a_reg : i == 1 ? b_reg :
                            i == 2 ? c_reg : i == 3 ? d_reg : i == 4 ? e_reg :
                            i == 5 ? f_reg : i == 6 ? g_reg : hh_reg);
                    end
                    if (fresh_reg)
                    begin
                        fresh_reg <= 1'b0;
                        pad_reg   <= '0;
                    end
                    if (ending_reg && fill >= 6'd56 && !second_reg)
                    begin
                        second_reg <= 1'b1;
                        pad_reg    <= '0;
                    end
                end
                ST_PAD:
                begin
                    pad_reg <= pad_reg + 6'd1;
                end
                ST_OUT:
                begin
                    if (out_take)
                    begin
                        word_reg <= word_reg + 3'd1;
                        if (word_reg == 3'd7)
                        begin
                            bytes_reg  <= '0;
                            ending_reg <= 1'b0;
                            for (int i = 0; i < 8; i++)
                            begin
                                h_reg[i] <= INIT_H[32*(7-i) +: 32];
                            end
                        end
                    end
                end
                default: cnt_reg <= '0;
            endcase
        end
    end

    // schedule window shifts by one each load step and each round; working variables
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_LOAD && cnt_reg != 7'd0)
        begin
            for (int i = 0; i < 15; i++)
            begin
                w_reg[i] <= w_reg[i+1];
            end
            w_reg[15] <= rd_word_reg;
            a_reg  <= h_reg[0];
            b_reg  <= h_reg[1];
            c_reg  <= h_reg[2];
            d_reg  <= h_reg[3];
            e_reg  <= h_reg[4];
            f_reg  <= h_reg[5];
            g_reg  <= h_reg[6];
            hh_reg <= h_reg[7];
        end
        else if (state_reg == ST_ROUND)
        begin
            for (int i = 0; i < 15; i++)
            begin
                w_reg[i] <= w_reg[i+1];
            end
            w_reg[15] <= w_new;
            hh_reg <= g_reg;
            g_reg  <= f_reg;
            f_reg  <= e_reg;
            e_reg  <= d_reg + t1;
            d_reg  <= c_reg;
            c_reg  <= b_reg;
            b_reg  <= a_reg;
            a_reg  <= t1 + t2;
        end
    end

    assign out_valid   = (state_reg == ST_OUT);
    assign digest_word = h_reg[word_reg];
    assign word_number = word_reg;
    assign final_word  = (word_reg == 3'd7);

    a_out_only_in_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> state_reg == ST_OUT)
        else $error("digest word outside output phase");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND) |-> in_stall)
        else $error("input taken during rounds");
    a_round_follows_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOAD && cnt_reg == 7'd16) |=> state_reg == ST_ROUND)
        else $error("rounds did not start after load");
    a_word_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> $stable(word_number))
        else $error("word index moved while stalled");

endmodule
`default_nettype wire

@@ verif/sha256_checker.sv @@
`timescale 1ns / 100ps
module sha256_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic        in_stall,
    input  wire logic [7:0]  message_byte,
    input  wire logic        has_byte,
    input  wire logic        ends_message,
    input  wire logic        out_valid,
    input  wire logic        out_stall,
    input  wire logic [31:0] digest_word,
    input  wire logic [2:0]  word_number,
    input  wire logic        final_word,
    output int               errors,
    output int               pending
);
    import sha_pkg::*;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  num;
        logic        fin;
    } digest_word_t;

    localparam logic [31:0] K_TAB [64] = '{
        32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
        32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
        32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
        32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
        32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
        32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
        32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
        32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
        32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
        32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
        32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
        32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
        32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
        32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
        32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
        32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
    };

    logic [31:0]  hash_state [8];
    logic [7:0]   block_buf [64];
    logic [60:0]  byte_count;
    digest_word_t digest_q [$];

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic compress_block();
        logic [31:0] w [16];
        logic [31:0] v [8];
        logic [31:0] wt, x15, x2, t1, t2;
        for (int i = 0; i < 16; i++)
            w[i] = {block_buf[4*i], block_buf[4*i+1], block_buf[4*i+2], block_buf[4*i+3]};
        for (int i = 0; i < 8; i++)
            v[i] = hash_state[i];
        for (int t = 0; t < 64; t++)
        begin
            if (t < 16)
                wt = w[t];
            else
            begin
                x15 = w[(t - 15) & 15];
                x2  = w[(t - 2) & 15];
                wt = w[t & 15] + (rotr(x15, 7) ^ rotr(x15, 18) ^ (x15 >> 3))
                     + w[(t - 7) & 15] + (rotr(x2, 17) ^ rotr(x2, 19) ^ (x2 >> 10));
                w[t & 15] = wt;
            end
            t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
                 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + K_TAB[t] + wt;
            t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
                 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
            hash_state[i] = hash_state[i] + v[i];
    endtask

    task automatic absorb(input logic [7:0] b, input logic hb, input logic em);
        int fill;
        logic [63:0] bit_len;
        digest_word_t d;
        if (hb)
        begin
            block_buf[byte_count[5:0]] = b;
            byte_count = byte_count + 61'd1;
            if (byte_count[5:0] == 6'd0)
                compress_block();
        end
        if (em)
        begin
            fill = int'(byte_count[5:0]);
            block_buf[fill] = PAD_BYTE;
            for (int i = fill + 1; i < 64; i++)
                block_buf[i] = 8'h00;
            // no room for the length field, spill into a second block
            if (fill >= 56)
            begin
                compress_block();
                for (int i = 0; i < 56; i++)
                    block_buf[i] = 8'h00;
            end
            bit_len = {byte_count, 3'b000};
            for (int i = 0; i < 8; i++)
                block_buf[63 - i] = bit_len[8*i +: 8];
            compress_block();
            for (int i = 0; i < 8; i++)
            begin
                d.word = hash_state[i];
                d.num = i[2:0];
                d.fin = (i == 7);
                digest_q.insert(digest_q.size(), d);
            end
            for (int i = 0; i < 8; i++)
                hash_state[i] = INIT_H[255 - 32*i -: 32];
            byte_count = '0;
        end
    endtask

    initial
    begin
        errors = 0;
        pending = 0;
        for (int i = 0; i < 8; i++)
            hash_state[i] = INIT_H[255 - 32*i -: 32];
        byte_count = '0;
    end

    always @(posedge clk)
    begin
        digest_word_t e;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                absorb(message_byte, has_byte, ends_message);
            if (out_valid && !out_stall)
            begin
                if (digest_q.size() == 0)
                begin
                    $error("digest word with no transaction pending: %h", digest_word);
                    errors++;
                end
                else
                begin
                    e = digest_q.pop_front();
                    if (digest_word !== e.word)
                    begin
                        $error("digest_word expected %h actual %h", e.word, digest_word);
                        errors++;
                    end
                    if (word_number !== e.num)
                    begin
                        $error("word_number expected %0d actual %0d", e.num, word_number);
                        errors++;
                    end
                    if (final_word !== e.fin)
                    begin
                        $error("final_word expected %0d actual %0d", e.fin, final_word);
                        errors++;
                    end
                end
            end
            pending = digest_q.size();
        end
    end

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 100ps
module tb;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  message_byte;
    logic        has_byte;
    logic        ends_message;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] digest_word;
    logic [2:0]  word_number;
    logic        final_word;
    int          errors;
    int          pending;
    int          byte_items;
    int          words_taken;
    bit          quiet_tx;
    bit          quiet_rx;
    longint      cycles;

    sha256_hasher_unit i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .message_byte (message_byte),
        .has_byte     (has_byte),
        .ends_message (ends_message),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .digest_word  (digest_word),
        .word_number  (word_number),
        .final_word   (final_word)
    );

    sha256_checker i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .message_byte (message_byte),
        .has_byte     (has_byte),
        .ends_message (ends_message),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .digest_word  (digest_word),
        .word_number  (word_number),
        .final_word   (final_word),
        .errors       (errors),
        .pending      (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > 600000)
            begin
                $display("tb: errors");
                $finish;
            end
        end
    end

    // receiver: random hold before each digest word unless quiet, one long hold to back up the block
    initial
    begin
        int hold;
        out_stall = 1'b1;
        words_taken = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (words_taken == 40)
                hold = 400;
            else if (quiet_rx)
                hold = 0;
            else
                hold = $urandom_range(0, 10);
            if (hold > 0)
            begin
                out_stall = 1'b1;
                repeat (hold) @(negedge clk);
            end
            out_stall = 1'b0;
            do
                @(posedge clk);
            while (!out_valid);
            words_taken++;
        end
    end

    task automatic send(input logic [7:0] b, input logic hb, input logic em);
        int gap;
        gap = quiet_tx ? 0 : $urandom_range(0, 10);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        message_byte = b;
        has_byte = hb;
        ends_message = em;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
        if (hb || em)
            byte_items++;
    endtask

    task automatic send_message(input int len, input bit end_on_byte);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 15) == 0)
                send(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            send(8'($urandom_range(0, 255)), 1'b1, end_on_byte && (i == len - 1));
        end
        if (!end_on_byte || len == 0)
            send(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    endtask

    initial
    begin
        int len;
        int sel;
        rst_n = 1'b0;
        in_valid = 1'b0;
        message_byte = '0;
        has_byte = 1'b0;
        ends_message = 1'b0;
        quiet_tx = 1'b0;
        quiet_rx = 1'b0;
        byte_items = 0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: empty message, idle transaction, abc, extreme bytes
        send(8'h00, 1'b0, 1'b1);
        send(8'hFF, 1'b0, 1'b0);
        send(8'h00, 1'b0, 1'b1);
        send(8'h61, 1'b1, 1'b0);
        send(8'h62, 1'b1, 1'b0);
        send(8'h63, 1'b1, 1'b0);
        send(8'h00, 1'b0, 1'b1);
        send(8'hFF, 1'b1, 1'b1);
        send(8'h00, 1'b1, 1'b1);
        send(8'hAA, 1'b1, 1'b0);
        send(8'h55, 1'b1, 1'b1);

        while (byte_items < 500)
        begin
            if ($urandom_range(0, 7) == 0)
                quiet_tx = 1'($urandom_range(0, 1));
            if ($urandom_range(0, 7) == 0)
                quiet_rx = 1'($urandom_range(0, 1));
            sel = $urandom_range(0, 9);
            if (sel < 5)
                len = $urandom_range(0, 12);
            else if (sel < 9)
                // lengths around the padding split and block edge
                len = $urandom_range(52, 68);
            else
                len = $urandom_range(100, 140);
            send_message(len, 1'($urandom_range(0, 1)));
        end
        in_valid = 1'b0;

        while (pending != 0)
            @(negedge clk);
        repeat (300) @(negedge clk);
        if (errors == 0 && pending == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
